// File: rtl/lsbe_pkg.sv
package lsbe_pkg;

    // Store geometry
    localparam int MAX_CARRIER_BYTES = 65536;
    localparam int ADDR_W            = 16;
    localparam int SIZE_W            = 17;
    localparam int STEP_LIMIT        = 2 * MAX_CARRIER_BYTES + 2;
    localparam int CNT_W             = $clog2(STEP_LIMIT + 2);

    // Key chain constants
    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_MULT  = 32'h0100_0193;

    // Function codes
    localparam logic [2:0] FUNC_LOAD    = 3'd0;
    localparam logic [2:0] FUNC_READ    = 3'd1;
    localparam logic [2:0] FUNC_BEGIN   = 3'd2;
    localparam logic [2:0] FUNC_EMBED   = 3'd3;
    localparam logic [2:0] FUNC_EXTRACT = 3'd4;

    // Galois tap masks, one per index width
    localparam logic [ADDR_W-1:0] TAP_TABLE [16] = '{
        16'h0001, 16'h0003, 16'h0006, 16'h000C,
        16'h0014, 16'h0030, 16'h0060, 16'h00B8,
        16'h0110, 16'h0240, 16'h0500, 16'h0CA0,
        16'h1B00, 16'h3500, 16'h6000, 16'hB400
    };

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_out;
        logic       planes_exhausted;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       rd_cursor;
        logic       rd_capture;
        logic       begin_cmd;
        logic       bit_commit;
        logic       adv_step;
        logic       key_update;
        logic       out_load;
        logic [2:0] bit_idx;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic adv_done;
        logic out_free;
    } t_dp_stat;

    // Index of the highest set bit
    function automatic logic [4:0] flog2(input logic [SIZE_W-1:0] a);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (a[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/lsbe_dpath.sv
module lsbe_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lsbe_pkg::t_in_word         i_in,
    input  logic [lsbe_pkg::SIZE_W-1:0] i_carrier_size,
    input  lsbe_pkg::t_dp_cmd          i_cmd,
    output lsbe_pkg::t_dp_stat         o_stat,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output lsbe_pkg::t_out_word        o_out
);
    import lsbe_pkg::*;

    logic [7:0]        r_mem [MAX_CARRIER_BYTES];
    logic [7:0]        r_rdata;
    logic [2:0]        r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_value;
    logic [7:0]        r_raw;
    logic [7:0]        r_result;
    logic [ADDR_W-1:0] r_cursor;
    logic [3:0]        r_plane;
    logic [ADDR_W-1:0] r_tap;
    logic [31:0]       r_key;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [SIZE_W-1:0] w_n;
    logic [SIZE_W-1:0] w_nm1;
    logic [4:0]        w_log;
    logic              w_lsb;
    logic [ADDR_W-1:0] w_next;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic              w_first_one;
    logic              w_runaway;
    logic              w_in_range;
    logic              w_plane_ok;
    logic [7:0]        w_enc;
    logic [7:0]        w_wr_byte;
    logic [7:0]        w_ext;
    logic [31:0]       w_key_x;
    logic [31:0]       w_key_prod;
    logic [ADDR_W-1:0] w_rd_addr;

    // Clamp the size in use to the legal range
    always_comb begin
        if (i_carrier_size < SIZE_W'(2)) begin
            w_n = SIZE_W'(2);
        end else if (i_carrier_size > SIZE_W'(MAX_CARRIER_BYTES)) begin
            w_n = SIZE_W'(MAX_CARRIER_BYTES);
        end else begin
            w_n = i_carrier_size;
        end
    end

    assign w_nm1 = w_n - SIZE_W'(1);
    assign w_log = flog2(w_nm1);

    // One Galois LFSR step
    assign w_lsb       = r_cursor[0] | (r_cursor == '0);
    assign w_next      = (r_cursor >> 1) ^ (w_lsb ? r_tap : '0);
    assign w_cnt_inc   = r_cnt + CNT_W'(1);
    assign w_first_one = (r_cnt == '0) && (r_cursor == ADDR_W'(1));
    assign w_runaway   = w_cnt_inc > CNT_W'(STEP_LIMIT);
    assign w_in_range  = {1'b0, w_next} < w_n;

    assign o_stat.adv_done = w_first_one || w_runaway || w_in_range;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Bit insertion and extraction
    assign w_plane_ok = !r_plane[3];
    assign w_enc      = r_value ^ r_key[7:0];
    always_comb begin
        w_wr_byte = r_rdata;
        w_wr_byte[r_plane[2:0]] = w_enc[i_cmd.bit_idx];
    end

    // Key chain update
    assign w_ext      = r_raw ^ r_key[7:0];
    assign w_key_x    = r_key ^ {24'b0, (r_func == FUNC_EMBED) ? r_value : w_ext};
    assign w_key_prod = w_key_x * FNV_MULT;

    // Carrier store
    assign w_rd_addr = i_cmd.rd_cursor ? r_cursor : r_addr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[r_addr] <= r_value;
        end else if (i_cmd.bit_commit && w_plane_ok && (r_func == FUNC_EMBED)) begin
            r_mem[r_cursor] <= w_wr_byte;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Hold the accepted word and per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_in.func;
            r_addr   <= i_in.address;
            r_value  <= i_in.value;
            r_raw    <= '0;
            r_result <= '0;
        end else begin
            if (i_cmd.bit_commit) begin
                r_raw[i_cmd.bit_idx] <= w_plane_ok & r_rdata[r_plane[2:0]];
            end
            if (i_cmd.rd_capture) begin
                r_result <= r_rdata;
            end else if (i_cmd.key_update && (r_func == FUNC_EXTRACT)) begin
                r_result <= w_ext;
            end
        end
    end

    // Cursor, plane, tap and key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_plane  <= '0;
            r_tap    <= '0;
            r_key    <= FNV_BASIS;
            r_cnt    <= '0;
        end else if (i_cmd.begin_cmd) begin
            r_cursor <= '0;
            r_plane  <= '0;
            r_tap    <= TAP_TABLE[w_log[3:0]];
            r_key    <= FNV_BASIS;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.adv_step) begin
                priority if (w_first_one) begin
                    if (w_plane_ok) begin
                        r_plane <= r_plane + 4'd1;
                    end
                    r_cursor <= '0;
                    r_cnt    <= '0;
                end else if (w_runaway) begin
                    r_cursor <= '0;
                    r_cnt    <= '0;
                end else if (w_in_range) begin
                    r_cursor <= w_next;
                    r_cnt    <= '0;
                end else begin
                    r_cursor <= w_next;
                    r_cnt    <= w_cnt_inc;
                end
            end
            if (i_cmd.key_update) begin
                r_key <= w_key_prod;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.data_out         <= r_result;
            r_out.planes_exhausted <= r_plane[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/lsbe_ctrl.sv
module lsbe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0]         i_func,
    output logic               o_ready,
    output lsbe_pkg::t_dp_cmd  o_cmd,
    input  lsbe_pkg::t_dp_stat i_stat
);
    import lsbe_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOAD   = 10'b00_0000_0010,
        S_RDREQ  = 10'b00_0000_0100,
        S_RDCAP  = 10'b00_0000_1000,
        S_BEGIN  = 10'b00_0001_0000,
        S_BIT_RD = 10'b00_0010_0000,
        S_BIT_WR = 10'b00_0100_0000,
        S_ADV    = 10'b00_1000_0000,
        S_KEY    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_bit;
    logic [2:0] n_bit;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.bit_idx = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_bit = '0;
                    unique case (i_func)
                        FUNC_LOAD:    n_state = S_LOAD;
                        FUNC_READ:    n_state = S_RDREQ;
                        FUNC_BEGIN:   n_state = S_BEGIN;
                        FUNC_EMBED:   n_state = S_BIT_RD;
                        FUNC_EXTRACT: n_state = S_BIT_RD;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state = S_DONE;
            end
            S_RDREQ: begin
                n_state = S_RDCAP;
            end
            S_RDCAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state = S_DONE;
            end
            S_BEGIN: begin
                o_cmd.begin_cmd = 1'b1;
                n_state = S_DONE;
            end
            S_BIT_RD: begin
                o_cmd.rd_cursor = 1'b1;
                n_state = S_BIT_WR;
            end
            S_BIT_WR: begin
                o_cmd.bit_commit = 1'b1;
                n_state = S_ADV;
            end
            // Step the LFSR until it lands inside the carrier, wraps to the next plane or hits the step limit
            S_ADV: begin
                o_cmd.adv_step = 1'b1;
                if (i_stat.adv_done) begin
                    if (r_bit == 3'd7) begin
                        n_state = S_KEY;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_state = S_BIT_RD;
                    end
                end
            end
            S_KEY: begin
                o_cmd.key_update = 1'b1;
                n_state = S_DONE;
            end
            // Hold until the output register frees up
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

endmodule

// File: rtl/lfsr_scattered_bitplane_embed_core.sv
// Load and begin pass through their own state, then S_DONE; read through S_RDREQ, S_RDCAP, S_DONE.
// Embed and extract run S_BIT_RD, S_BIT_WR and S_ADV for each of the 8 bits, then S_KEY and S_DONE;
// S_ADV makes LFSR steps (one per cycle, at least 1 per bit, more when the sequence passes the
// carrier size); each bit reads the store, and embed also writes the changed byte back.
// One word is in work at a time; the next is taken as soon as the result is registered.
// Reset (synchronous, active low) clears cursor, plane, tap mask, resets key; the store is not cleared.
module lfsr_scattered_bitplane_embed_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lsbe_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output lsbe_pkg::t_out_word o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lsbe_pkg::*;

    localparam logic REG_CARRIER_SIZE = 1'b0;

    logic [SIZE_W-1:0] r_carrier_size;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_size <= SIZE_W'(MAX_CARRIER_BYTES);
        end else if (psel && penable && pwrite && (paddr[2] == REG_CARRIER_SIZE)) begin
            r_carrier_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CARRIER_SIZE) ?
                    {{(32 - SIZE_W){1'b0}}, r_carrier_size} : '0;

    lsbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_data.func),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    lsbe_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_data),
        .i_carrier_size (r_carrier_size),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_out          (o_data)
    );

endmodule
